// ===== hdl/kcs_pkg.sv =====
// Shared types, codes and helpers for the keyframe channel sampler
package kcs_pkg;

	localparam int MaxKeysDef = 256;
	localparam int AddrMaxW   = 12;
	localparam int CountW     = 9;
	localparam int CompW      = 32;
	localparam int DivNumW    = 61;
	localparam int DivSteps   = 61;
	localparam int SqrtSteps  = 32;

	// opcodes of an input word
	localparam logic [1:0] OP_WR_TRANS = 2'd0;
	localparam logic [1:0] OP_WR_ROT   = 2'd1;
	localparam logic [1:0] OP_WR_SCALE = 2'd2;
	localparam logic [1:0] OP_SAMPLE   = 2'd3;

	// table selects, also configuration register indexes
	localparam logic [1:0] TBL_TRANS = 2'd0;
	localparam logic [1:0] TBL_ROT   = 2'd1;
	localparam logic [1:0] TBL_SCALE = 2'd2;

	// datapath commands
	typedef enum logic [4:0] {
		DC_NOP, DC_WRITE, DC_LOAD, DC_EMPTY, DC_CAP_T1, DC_CAP_T0, DC_CAP_ALPHA,
		DC_HOLD, DC_HOLD_CLAMP, DC_CAP_A, DC_CAP_B, DC_MUL, DC_ADD, DC_SQ,
		DC_SQACC, DC_SQRT, DC_QDIV, DC_QCAP, DC_RZERO, DC_DONE
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t               cmd;
		logic [1:0]            tbl;
		logic [1:0]            comp;
		logic [AddrMaxW-1:0]   addr;
	} dp_ctl_t;

	typedef struct packed {
		logic t_lt_rd;
		logic t_le_rd;
		logic div_done;
		logic sqrt_done;
		logic m_zero;
	} dp_sts_t;

	// number of components of a table
	function automatic logic [2:0] tbl_comps(input logic [1:0] tbl);
		logic [2:0] n;
		case (tbl)
			TBL_ROT: n = 3'd4;
			default: n = 3'd3;
		endcase
		return n;
	endfunction

	// first result slot of a table
	function automatic logic [3:0] tbl_base(input logic [1:0] tbl);
		logic [3:0] b;
		case (tbl)
			TBL_TRANS: b = 4'd0;
			TBL_ROT:   b = 4'd3;
			default:   b = 4'd7;
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/keyframe_channel_sampler.sv =====
// Channel   | Signals                                   | Handshake
// input     | opcode key_index time_value comp_x..w     | start && !busy
// config    | cfg_index cfg_data                        | cfg_we
// result    | trans_* rot_* scale_* *_kinds             | done, one cycle
//
// A key write completes in the accept cycle and gives no result word.
// A sample scans each table for its segment (one store read port per table)
// and uses the shared restoring divider for at most one alpha per table and,
// after the square root, for the four quaternion parts.
// Reset clears the key counts and the controller; key stores are not cleared.
// The result receiver cannot stall; done is high for one cycle.
module keyframe_channel_sampler #(
	parameter int MAX_KEYS = kcs_pkg::MaxKeysDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [7:0]                    key_index,
	input  logic [31:0]                   time_value,
	input  logic signed [31:0]            comp_x,
	input  logic signed [31:0]            comp_y,
	input  logic signed [31:0]            comp_z,
	input  logic signed [31:0]            comp_w,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [kcs_pkg::CountW-1:0]    cfg_data,
	output logic                          done,
	output logic signed [31:0]            trans_x,
	output logic signed [31:0]            trans_y,
	output logic signed [31:0]            trans_z,
	output logic signed [31:0]            rot_x,
	output logic signed [31:0]            rot_y,
	output logic signed [31:0]            rot_z,
	output logic signed [31:0]            rot_w,
	output logic signed [31:0]            scale_x,
	output logic signed [31:0]            scale_y,
	output logic signed [31:0]            scale_z,
	output logic [2:0]                    clamped_kinds,
	output logic [2:0]                    empty_kinds
);

	kcs_pkg::dp_ctl_t   ctl;
	kcs_pkg::dp_sts_t   sts;
	logic signed [31:0] res [10];

	kcs_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts)
	);

	kcs_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.opcode        (opcode),
		.key_index     (key_index),
		.time_value    (time_value),
		.comp_x        (comp_x),
		.comp_y        (comp_y),
		.comp_z        (comp_z),
		.comp_w        (comp_w),
		.done          (done),
		.res_out       (res),
		.clamped_kinds (clamped_kinds),
		.empty_kinds   (empty_kinds)
	);

	// result word fields
	assign trans_x = res[0];
	assign trans_y = res[1];
	assign trans_z = res[2];
	assign rot_x   = res[3];
	assign rot_y   = res[4];
	assign rot_z   = res[5];
	assign rot_w   = res[6];
	assign scale_x = res[7];
	assign scale_y = res[8];
	assign scale_z = res[9];

endmodule

// ===== hdl/kcs_div.sv =====
// Restoring divider, one quotient bit a cycle
module kcs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [kcs_pkg::DivNumW-1:0]    num,
	input  logic [31:0]                    den,
	output logic                           done,
	output logic [kcs_pkg::DivNumW-1:0]    quot
);

	logic [kcs_pkg::DivNumW-1:0] num_q;
	logic [31:0]                 rem_q;
	logic [31:0]                 den_q;
	logic [5:0]                  cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [32:0]                 rem_sh;
	logic                        fits;

	assign rem_sh = {rem_q, num_q[kcs_pkg::DivNumW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(kcs_pkg::DivSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			num_q <= {num_q[kcs_pkg::DivNumW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== hdl/kcs_sqrt.sv =====
// Integer square root, one root bit a cycle
module kcs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(kcs_pkg::SqrtSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// digit-by-digit step
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
		end else if (run_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[63:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

// ===== hdl/kcs_dp.sv =====
// Datapath: key tables, interpolation, nlerp normalisation
module kcs_dp #(
	parameter int MAX_KEYS = kcs_pkg::MaxKeysDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kcs_pkg::dp_ctl_t     ctl,
	output kcs_pkg::dp_sts_t     sts,
	input  logic [1:0]           opcode,
	input  logic [7:0]           key_index,
	input  logic [31:0]          time_value,
	input  logic signed [31:0]   comp_x,
	input  logic signed [31:0]   comp_y,
	input  logic signed [31:0]   comp_z,
	input  logic signed [31:0]   comp_w,
	output logic                 done,
	output logic signed [31:0]   res_out [10],
	output logic [2:0]           clamped_kinds,
	output logic [2:0]           empty_kinds
);

	localparam int AW = $clog2(MAX_KEYS);

	// key stores
	logic [31:0]  tt_mem [MAX_KEYS];
	logic [31:0]  rt_mem [MAX_KEYS];
	logic [31:0]  st_mem [MAX_KEYS];
	logic [95:0]  tv_mem [MAX_KEYS];
	logic [127:0] rv_mem [MAX_KEYS];
	logic [95:0]  sv_mem [MAX_KEYS];

	logic [31:0]  tt_rd_q, rt_rd_q, st_rd_q;
	logic [95:0]  tv_rd_q, sv_rd_q;
	logic [127:0] rv_rd_q;

	logic [31:0]  kidx_ext;
	logic [AW-1:0] waddr, raddr;
	logic         key_ok;

	logic [31:0]  t_q, t1_q;
	logic [15:0]  alpha_q;
	logic [127:0] a_q, b_q;
	logic signed [49:0] prod_s1;
	logic signed [63:0] sq_s1;
	logic [63:0]  s_q;
	logic signed [31:0] res_q [10];
	logic [2:0]   clamp_q, empty_q;

	logic [31:0]  time_rd;
	logic [127:0] val_rd;
	logic [3:0]   ridx;
	logic [2:0]   nc;
	logic signed [31:0] a_j, b_j, c_j;
	logic signed [32:0] d_j;
	logic signed [49:0] sum_j;
	logic [31:0]  mag_j;

	logic         div_start, div_done;
	logic [kcs_pkg::DivNumW-1:0] div_num, div_quot;
	logic [31:0]  div_den;
	logic         sqrt_start, sqrt_done;
	logic [31:0]  root;

	assign kidx_ext = 32'(key_index);
	assign waddr    = kidx_ext[AW-1:0];
	assign key_ok   = kidx_ext < MAX_KEYS;
	assign raddr    = ctl.addr[AW-1:0];

	// key writes straight from the accepted word
	always_ff @(posedge clk) begin
		if (ctl.cmd == kcs_pkg::DC_WRITE && key_ok) begin
			case (opcode)
				kcs_pkg::OP_WR_TRANS: begin
					tt_mem[waddr] <= time_value;
					tv_mem[waddr] <= {comp_z, comp_y, comp_x};
				end
				kcs_pkg::OP_WR_ROT: begin
					rt_mem[waddr] <= time_value;
					rv_mem[waddr] <= {comp_w, comp_z, comp_y, comp_x};
				end
				kcs_pkg::OP_WR_SCALE: begin
					st_mem[waddr] <= time_value;
					sv_mem[waddr] <= {comp_z, comp_y, comp_x};
				end
				default: ;
			endcase
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		tt_rd_q <= tt_mem[raddr];
		rt_rd_q <= rt_mem[raddr];
		st_rd_q <= st_mem[raddr];
		tv_rd_q <= tv_mem[raddr];
		rv_rd_q <= rv_mem[raddr];
		sv_rd_q <= sv_mem[raddr];
	end

	// table select and operand picks
	always_comb begin
		case (ctl.tbl)
			kcs_pkg::TBL_TRANS: begin
				time_rd = tt_rd_q;
				val_rd  = {32'd0, tv_rd_q};
			end
			kcs_pkg::TBL_ROT: begin
				time_rd = rt_rd_q;
				val_rd  = rv_rd_q;
			end
			default: begin
				time_rd = st_rd_q;
				val_rd  = {32'd0, sv_rd_q};
			end
		endcase
	end

	assign nc    = kcs_pkg::tbl_comps(ctl.tbl);
	assign ridx  = kcs_pkg::tbl_base(ctl.tbl) + 4'(ctl.comp);
	assign a_j   = a_q[32*ctl.comp +: 32];
	assign b_j   = b_q[32*ctl.comp +: 32];
	assign c_j   = res_q[ridx];
	assign d_j   = {b_j[31], b_j} - {a_j[31], a_j};
	assign sum_j = {{18{a_j[31]}}, a_j} + (prod_s1 >>> 16);
	assign mag_j = c_j[31] ? 32'(-c_j) : c_j;

	// shared divider: alpha, then the quaternion parts
	assign div_start = (ctl.cmd == kcs_pkg::DC_CAP_T0 && !sts.t_le_rd) ||
		(ctl.cmd == kcs_pkg::DC_QDIV);
	assign div_num = (ctl.cmd == kcs_pkg::DC_QDIV) ? {mag_j, 29'd0} :
		kcs_pkg::DivNumW'({32'(t_q - time_rd), 16'd0});
	assign div_den = (ctl.cmd == kcs_pkg::DC_QDIV) ? root : 32'(t1_q - time_rd);

	kcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign sqrt_start = ctl.cmd == kcs_pkg::DC_SQRT;

	kcs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (s_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// working and result registers
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			kcs_pkg::DC_LOAD: begin
				t_q     <= time_value;
				clamp_q <= '0;
				empty_q <= '0;
			end
			kcs_pkg::DC_EMPTY: begin
				for (int jj = 0; jj < 4; jj++) begin
					if (jj < int'(nc)) res_q[kcs_pkg::tbl_base(ctl.tbl) + 4'(jj)] <= '0;
				end
				empty_q[ctl.tbl] <= 1'b1;
			end
			kcs_pkg::DC_HOLD, kcs_pkg::DC_HOLD_CLAMP: begin
				for (int jj = 0; jj < 4; jj++) begin
					if (jj < int'(nc))
						res_q[kcs_pkg::tbl_base(ctl.tbl) + 4'(jj)] <= val_rd[32*jj +: 32];
				end
				if (ctl.cmd == kcs_pkg::DC_HOLD_CLAMP) clamp_q[ctl.tbl] <= 1'b1;
			end
			kcs_pkg::DC_CAP_T1: t1_q <= time_rd;
			kcs_pkg::DC_CAP_T0: if (sts.t_le_rd) alpha_q <= '0;
			kcs_pkg::DC_CAP_ALPHA: alpha_q <= div_quot[15:0];
			kcs_pkg::DC_CAP_A: a_q <= val_rd;
			kcs_pkg::DC_CAP_B: b_q <= val_rd;
			kcs_pkg::DC_MUL: prod_s1 <= d_j * $signed({1'b0, alpha_q});
			kcs_pkg::DC_ADD: res_q[ridx] <= sum_j[31:0];
			kcs_pkg::DC_SQ: sq_s1 <= c_j * c_j;
			kcs_pkg::DC_SQACC: s_q <= ((ctl.comp == 2'd0) ? 64'd0 : s_q) +
				{2'b00, sq_s1[63:2]};
			kcs_pkg::DC_QCAP: begin
				if (c_j[31])
					res_q[ridx] <= (div_quot > kcs_pkg::DivNumW'(33'h080000000)) ?
						32'sh80000000 : 32'(-div_quot[31:0]);
				else
					res_q[ridx] <= (div_quot > kcs_pkg::DivNumW'(32'h7FFFFFFF)) ?
						32'sh7FFFFFFF : div_quot[31:0];
			end
			kcs_pkg::DC_RZERO: begin
				for (int jj = 3; jj < 7; jj++) res_q[jj] <= '0;
			end
			default: ;
		endcase
	end

	assign sts.t_lt_rd   = t_q < time_rd;
	assign sts.t_le_rd   = t_q <= time_rd;
	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.m_zero    = root == 32'd0;

	assign done          = ctl.cmd == kcs_pkg::DC_DONE;
	assign res_out       = res_q;
	assign clamped_kinds = clamp_q;
	assign empty_kinds   = empty_q;

endmodule

// ===== hdl/kcs_ctrl.sv =====
// Controller: segment scan and sequencing of the datapath
module kcs_ctrl #(
	parameter int MAX_KEYS = kcs_pkg::MaxKeysDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    opcode,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [kcs_pkg::CountW-1:0]    cfg_data,
	output kcs_pkg::dp_ctl_t              ctl,
	input  kcs_pkg::dp_sts_t              sts
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int NW = $clog2(MAX_KEYS + 1);

	localparam logic [1:0] KIND_INTERP = 2'd0;
	localparam logic [1:0] KIND_SINGLE = 2'd1;
	localparam logic [1:0] KIND_CLAMP  = 2'd2;

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001, ST_INIT  = 20'h00002, ST_SCAN_A = 20'h00004,
		ST_SCAN_C = 20'h00008, ST_T0_A = 20'h00010, ST_T0_C  = 20'h00020,
		ST_ADIV  = 20'h00040, ST_VA_A  = 20'h00080, ST_VA_C  = 20'h00100,
		ST_VB_A  = 20'h00200, ST_VB_C  = 20'h00400, ST_MUL   = 20'h00800,
		ST_ADD   = 20'h01000, ST_SQ    = 20'h02000, ST_SQACC = 20'h04000,
		ST_SQRT  = 20'h08000, ST_SQRTW = 20'h10000, ST_QDIV  = 20'h20000,
		ST_QDIVW = 20'h40000, ST_NEXT  = 20'h80000
	} state_t;

	state_t state_q, state_d;
	logic [1:0]    k_q, k_d, j_q, j_d, kind_q, kind_d;
	logic [AW-1:0] i_q, i_d;
	logic [kcs_pkg::CountW-1:0] cnt_q [3];
	logic [31:0]   c32, n32;
	logic [NW-1:0] n;
	logic [1:0]    j_last;

	// key counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) cnt_q[r] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kcs_pkg::TBL_TRANS: cnt_q[0] <= cfg_data;
				kcs_pkg::TBL_ROT:   cnt_q[1] <= cfg_data;
				kcs_pkg::TBL_SCALE: cnt_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// keys in the current table, capped at the store depth
	always_comb begin
		case (k_q)
			kcs_pkg::TBL_TRANS: c32 = 32'(cnt_q[0]);
			kcs_pkg::TBL_ROT:   c32 = 32'(cnt_q[1]);
			default:            c32 = 32'(cnt_q[2]);
		endcase
		n32 = (c32 > MAX_KEYS) ? 32'(MAX_KEYS) : c32;
	end
	assign n      = n32[NW-1:0];
	assign j_last = 2'(kcs_pkg::tbl_comps(k_q) - 3'd1);

	// next state and commands
	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		j_d      = j_q;
		i_d      = i_q;
		kind_d   = kind_q;
		ctl.cmd  = kcs_pkg::DC_NOP;
		ctl.tbl  = k_q;
		ctl.comp = j_q;
		ctl.addr = kcs_pkg::AddrMaxW'(i_q);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == kcs_pkg::OP_SAMPLE) begin
						ctl.cmd = kcs_pkg::DC_LOAD;
						k_d     = kcs_pkg::TBL_TRANS;
						state_d = ST_INIT;
					end else begin
						ctl.cmd = kcs_pkg::DC_WRITE;
					end
				end
			end
			ST_INIT: begin
				i_d = '0;
				j_d = '0;
				if (n == '0) begin
					ctl.cmd = kcs_pkg::DC_EMPTY;
					state_d = ST_NEXT;
				end else if (n == NW'(1)) begin
					kind_d  = KIND_SINGLE;
					state_d = ST_VA_A;
				end else begin
					state_d = ST_SCAN_A;
				end
			end
			ST_SCAN_A: begin
				ctl.addr = kcs_pkg::AddrMaxW'(i_q + AW'(1));
				state_d  = ST_SCAN_C;
			end
			ST_SCAN_C: begin
				if (sts.t_lt_rd) begin
					ctl.cmd = kcs_pkg::DC_CAP_T1;
					kind_d  = KIND_INTERP;
					state_d = ST_T0_A;
				end else if (NW'(i_q) + NW'(2) == n) begin
					i_d     = i_q + AW'(1);
					kind_d  = KIND_CLAMP;
					state_d = ST_VA_A;
				end else begin
					i_d     = i_q + AW'(1);
					state_d = ST_SCAN_A;
				end
			end
			ST_T0_A: state_d = ST_T0_C;
			ST_T0_C: begin
				ctl.cmd = kcs_pkg::DC_CAP_T0;
				state_d = sts.t_le_rd ? ST_VA_A : ST_ADIV;
			end
			ST_ADIV: begin
				if (sts.div_done) begin
					ctl.cmd = kcs_pkg::DC_CAP_ALPHA;
					state_d = ST_VA_A;
				end
			end
			ST_VA_A: state_d = ST_VA_C;
			ST_VA_C: begin
				case (kind_q)
					KIND_SINGLE: begin
						ctl.cmd = kcs_pkg::DC_HOLD;
						state_d = ST_NEXT;
					end
					KIND_CLAMP: begin
						ctl.cmd = kcs_pkg::DC_HOLD_CLAMP;
						state_d = ST_NEXT;
					end
					default: begin
						ctl.cmd = kcs_pkg::DC_CAP_A;
						state_d = ST_VB_A;
					end
				endcase
			end
			ST_VB_A: begin
				ctl.addr = kcs_pkg::AddrMaxW'(i_q + AW'(1));
				state_d  = ST_VB_C;
			end
			ST_VB_C: begin
				ctl.cmd = kcs_pkg::DC_CAP_B;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				ctl.cmd = kcs_pkg::DC_MUL;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				ctl.cmd = kcs_pkg::DC_ADD;
				if (j_q == j_last) begin
					j_d     = '0;
					state_d = (k_q == kcs_pkg::TBL_ROT) ? ST_SQ : ST_NEXT;
				end else begin
					j_d     = j_q + 2'd1;
					state_d = ST_MUL;
				end
			end
			ST_SQ: begin
				ctl.cmd = kcs_pkg::DC_SQ;
				state_d = ST_SQACC;
			end
			ST_SQACC: begin
				ctl.cmd = kcs_pkg::DC_SQACC;
				if (j_q == 2'd3) begin
					j_d     = '0;
					state_d = ST_SQRT;
				end else begin
					j_d     = j_q + 2'd1;
					state_d = ST_SQ;
				end
			end
			ST_SQRT: begin
				ctl.cmd = kcs_pkg::DC_SQRT;
				state_d = ST_SQRTW;
			end
			ST_SQRTW: begin
				if (sts.sqrt_done) begin
					if (sts.m_zero) begin
						ctl.cmd = kcs_pkg::DC_RZERO;
						state_d = ST_NEXT;
					end else begin
						state_d = ST_QDIV;
					end
				end
			end
			ST_QDIV: begin
				ctl.cmd = kcs_pkg::DC_QDIV;
				state_d = ST_QDIVW;
			end
			ST_QDIVW: begin
				if (sts.div_done) begin
					ctl.cmd = kcs_pkg::DC_QCAP;
					if (j_q == 2'd3) begin
						state_d = ST_NEXT;
					end else begin
						j_d     = j_q + 2'd1;
						state_d = ST_QDIV;
					end
				end
			end
			ST_NEXT: begin
				if (k_q == kcs_pkg::TBL_SCALE) begin
					ctl.cmd = kcs_pkg::DC_DONE;
					state_d = ST_IDLE;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = ST_INIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
			i_q     <= '0;
			kind_q  <= KIND_INTERP;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
			i_q     <= i_d;
			kind_q  <= kind_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && opcode == kcs_pkg::OP_SAMPLE) |=> state_q == ST_INIT)
		else $error("sample word not taken up");
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && opcode != kcs_pkg::OP_SAMPLE) |=> !busy)
		else $error("key write left block busy");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == kcs_pkg::DC_DONE) |-> (k_q == kcs_pkg::TBL_SCALE))
		else $error("result word before last table");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_C) |-> (NW'(i_q) + NW'(2) <= n))
		else $error("scan ran past last key");

endmodule
